[rtl/core/fpmf_pkg.sv]
// Shared types and constants for the four-pole multimode filter.
package fpmf_pkg;

  localparam int FRAC_BITS  = 20;
  localparam int ONE_Q      = 1 << FRAC_BITS;
  localparam int FIELD_W    = 24;
  localparam int IN_TDATA_W = 3 * FIELD_W;
  localparam int CUT_W      = 24;
  localparam int RES_W      = 28;
  localparam int WEIGHT_W   = 21;
  localparam int SCALE_W    = 24;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int OVERSAMPLE_PASSES_DEF = 2;
  localparam int SAMPLE_BITS_DEF       = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOWPASS,
    MODE_HIGHPASS,
    MODE_BANDPASS,
    MODE_BANDREJECT
  } mode_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FILTER_MODE,
    REG_BASE_CUTOFF,
    REG_BASE_RESONANCE,
    REG_RESONANCE_SCALE,
    REG_FEEDBACK_SMOOTHING,
    REG_FEEDBACK_PHASE_MIX,
    REG_CUTOFF_VARIES,
    REG_RESONANCE_VARIES
  } reg_e;

  // Operand pairs for the shared multiplier
  typedef enum logic [4:0] {
    OP_NONE,
    OP_BR_SC,    // base resonance * resonance scale
    OP_R0_RF,    // previous product * resonance factor
    OP_CF_BC,    // cutoff factor * base cutoff
    OP_FB_S,     // feedback * smoothing
    OP_R_S4,     // resonance * stage four
    OP_T_NS,     // previous product * (one - smoothing)
    OP_PREV_NP,  // clamped old feedback * (one - phase mix)
    OP_FB_P,     // new feedback * phase mix
    OP_S1_K,
    OP_X_C,
    OP_S2_K,
    OP_S1_C,
    OP_S3_K,
    OP_S2_C,
    OP_S4_K,
    OP_S3_C
  } mul_op_e;

  typedef struct packed {
    logic    start;
    mul_op_e op;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    mode_e               mode;
    logic [WEIGHT_W-1:0] base_cutoff;
    logic [WEIGHT_W-1:0] base_resonance;
    logic [SCALE_W-1:0]  resonance_scale;
    logic [WEIGHT_W-1:0] feedback_smoothing;
    logic [WEIGHT_W-1:0] feedback_phase_mix;
    logic                cutoff_varies;
    logic                resonance_varies;
  } cfg_t;

endpackage

[rtl/core/fpmf_ctrl.sv]
// Sequencer that steps the shared multiplier through setup, passes and output.
module fpmf_ctrl import fpmf_pkg::*; #(
  parameter int OVERSAMPLE_PASSES = OVERSAMPLE_PASSES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int STEP_W      = 4;
  localparam int SETUP_STEPS = 3;
  localparam int PASS_STEPS  = 13;
  localparam int PASS_W      = (OVERSAMPLE_PASSES > 1) ? $clog2(OVERSAMPLE_PASSES) : 1;

  localparam logic [STEP_W-1:0] LAST_SETUP = STEP_W'(SETUP_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(PASS_STEPS - 1);
  localparam logic [PASS_W-1:0] LAST_PASS  = PASS_W'(OVERSAMPLE_PASSES - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_PASS  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [PASS_W-1:0] pass_q, pass_d;

  function automatic mul_op_e setup_op(input logic [STEP_W-1:0] step);
    mul_op_e op;
    unique case (step)
      4'd0:    op = OP_BR_SC;
      4'd1:    op = OP_R0_RF;
      4'd2:    op = OP_CF_BC;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  // Each stage issues its own old value * k before the new input * c,
  // so the write-back of the previous stage lands in time.
  function automatic mul_op_e pass_op(input logic [STEP_W-1:0] step);
    mul_op_e op;
    unique case (step)
      4'd0:    op = OP_FB_S;
      4'd1:    op = OP_R_S4;
      4'd2:    op = OP_T_NS;
      4'd3:    op = OP_PREV_NP;
      4'd4:    op = OP_FB_P;
      4'd5:    op = OP_S1_K;
      4'd6:    op = OP_X_C;
      4'd7:    op = OP_S2_K;
      4'd8:    op = OP_S1_C;
      4'd9:    op = OP_S3_K;
      4'd10:   op = OP_S2_C;
      4'd11:   op = OP_S4_K;
      4'd12:   op = OP_S3_C;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    pass_d         = pass_q;
    in_ready_o     = 1'b0;
    cmd_o.start    = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          step_d      = '0;
          pass_d      = '0;
          state_d     = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.op = setup_op(step_q);
        if (step_q == LAST_SETUP) begin
          step_d  = '0;
          state_d = ST_PASS;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_PASS: begin
        cmd_o.op = pass_op(step_q);
        if (step_q == LAST_STEP) begin
          step_d = '0;
          if (pass_q == LAST_PASS) begin
            state_d = ST_DRAIN;
          end else begin
            pass_d = pass_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // last product of the final pass is written back here
      ST_DRAIN: state_d = ST_OUT;
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

endmodule

[rtl/core/fpmf_datapath.sv]
// Shared rounding multiplier, accumulator, filter state and output register.
module fpmf_datapath import fpmf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o,
  input  logic signed [FIELD_W-1:0] sample_in_i,
  input  logic signed [FIELD_W-1:0] cutoff_factor_i,
  input  logic signed [FIELD_W-1:0] resonance_factor_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [FIELD_W-1:0]        sample_out_o
);

  localparam int SW     = SAMPLE_BITS;
  localparam int S1_W   = (SW > FRAC_BITS + 2) ? SW : FRAC_BITS + 2;
  localparam int MA     = (SW + 8 > RES_W) ? SW + 8 : RES_W;
  localparam int MB     = (SW > CUT_W + 1) ? SW : CUT_W + 1;
  localparam int PROD_W = MA + MB;
  localparam int PW     = PROD_W + 1 - FRAC_BITS;
  localparam int AW     = PW + 2;
  localparam int KW     = CUT_W + 1;
  localparam int NW     = WEIGHT_W + 1;

  localparam longint SW_MAX_L  = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint CUT_MAX_L = (longint'(1) <<< (CUT_W - 1)) - 1;
  localparam longint RES_MAX_L = (longint'(1) <<< (RES_W - 1)) - 1;

  localparam logic signed [AW-1:0] SW_MAX  = AW'(SW_MAX_L);
  localparam logic signed [AW-1:0] SW_MIN  = AW'(-SW_MAX_L - 1);
  localparam logic signed [AW-1:0] CUT_MAX = AW'(CUT_MAX_L);
  localparam logic signed [AW-1:0] CUT_MIN = AW'(-CUT_MAX_L - 1);
  localparam logic signed [AW-1:0] RES_MAX = AW'(RES_MAX_L);
  localparam logic signed [AW-1:0] RES_MIN = AW'(-RES_MAX_L - 1);
  localparam logic signed [AW-1:0] ONE_POS = AW'(ONE_Q);
  localparam logic signed [AW-1:0] ONE_NEG = AW'(-ONE_Q);
  localparam logic signed [PROD_W:0] HALF  = (PROD_W + 1)'(ONE_Q / 2);

  function automatic logic signed [AW-1:0] clamp(input logic signed [AW-1:0] v,
                                                 input logic signed [AW-1:0] lo,
                                                 input logic signed [AW-1:0] hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // filter state
  logic signed [SW-1:0]   fb_q, fb_d;
  logic signed [S1_W-1:0] s1_q, s1_d;
  logic signed [SW-1:0]   s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  mul_op_e                op_q, op_d;
  logic                   out_valid_q, out_valid_d;

  // per-sample operands and working values
  logic signed [SW-1:0]      x_in_q, x_in_d, x_q, x_d;
  logic signed [FIELD_W-1:0] cf_q, cf_d, rf_q, rf_d;
  logic signed [CUT_W-1:0]   c_q, c_d;
  logic signed [KW-1:0]      k_q, k_d;
  logic signed [RES_W-1:0]   r_q, r_d;
  logic signed [PW-1:0]      acc_q, acc_d, p_q, p_d;
  logic [FIELD_W-1:0]        out_data_q, out_data_d;

  logic signed [MA-1:0]     mul_a, fb_ext, prev_a;
  logic signed [MB-1:0]     mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   prod_r;
  logic signed [NW-1:0]     ns, np;
  logic signed [AW-1:0]     p_ext, p_sum, y_sum;
  logic signed [CUT_W-1:0]  c_new;
  logic signed [RES_W-1:0]  r_new;
  logic signed [SW-1:0]     y_sat;

  assign ns = $signed(NW'(ONE_Q)) - $signed({1'b0, cfg_i.feedback_smoothing});
  assign np = $signed(NW'(ONE_Q)) - $signed({1'b0, cfg_i.feedback_phase_mix});

  // only the upper side of the old feedback is clamped
  assign fb_ext = MA'(fb_q);
  assign prev_a = (fb_ext > MA'(ONE_Q)) ? MA'(ONE_Q) : fb_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_BR_SC: begin
        mul_a = MA'(cfg_i.base_resonance);
        mul_b = MB'(cfg_i.resonance_scale);
      end
      OP_R0_RF: begin
        mul_a = MA'(p_q);
        mul_b = MB'(rf_q);
      end
      OP_CF_BC: begin
        mul_a = MA'(cf_q);
        mul_b = MB'(cfg_i.base_cutoff);
      end
      OP_FB_S: begin
        mul_a = MA'(fb_q);
        mul_b = MB'(cfg_i.feedback_smoothing);
      end
      OP_R_S4: begin
        mul_a = MA'(r_q);
        mul_b = MB'(s4_q);
      end
      OP_T_NS: begin
        mul_a = MA'(p_q);
        mul_b = MB'(ns);
      end
      OP_PREV_NP: begin
        mul_a = prev_a;
        mul_b = MB'(np);
      end
      OP_FB_P: begin
        mul_a = MA'(fb_q);
        mul_b = MB'(cfg_i.feedback_phase_mix);
      end
      OP_S1_K: begin
        mul_a = MA'(s1_q);
        mul_b = MB'(k_q);
      end
      OP_X_C: begin
        mul_a = MA'(x_q);
        mul_b = MB'(c_q);
      end
      OP_S2_K: begin
        mul_a = MA'(s2_q);
        mul_b = MB'(k_q);
      end
      OP_S1_C: begin
        mul_a = MA'(s1_q);
        mul_b = MB'(c_q);
      end
      OP_S3_K: begin
        mul_a = MA'(s3_q);
        mul_b = MB'(k_q);
      end
      OP_S2_C: begin
        mul_a = MA'(s2_q);
        mul_b = MB'(c_q);
      end
      OP_S4_K: begin
        mul_a = MA'(s4_q);
        mul_b = MB'(k_q);
      end
      OP_S3_C: begin
        mul_a = MA'(s3_q);
        mul_b = MB'(c_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up, drop the fraction
  assign prod   = mul_a * mul_b;
  assign prod_r = (PROD_W + 1)'(prod) + HALF;
  assign p_d    = $signed(prod_r[PROD_W:FRAC_BITS]);
  assign op_d   = cmd_i.op;

  assign p_ext = AW'(p_q);
  assign p_sum = AW'(acc_q) + p_ext;
  assign c_new = CUT_W'(clamp(p_ext, CUT_MIN, CUT_MAX));
  assign r_new = RES_W'(clamp(p_ext, RES_MIN, RES_MAX));

  // capture the sample operands on start, and write back the product issued in the previous cycle
  always_comb begin
    fb_d   = fb_q;
    s1_d   = s1_q;
    s2_d   = s2_q;
    s3_d   = s3_q;
    s4_d   = s4_q;
    x_in_d = x_in_q;
    cf_d   = cf_q;
    rf_d   = rf_q;
    c_d    = c_q;
    k_d    = k_q;
    r_d    = r_q;
    x_d    = x_q;
    acc_d  = acc_q;
    if (cmd_i.start) begin
      x_in_d = SW'(clamp(AW'(sample_in_i), SW_MIN, SW_MAX));
      cf_d   = cutoff_factor_i;
      rf_d   = resonance_factor_i;
      c_d    = CUT_W'(cfg_i.base_cutoff);
      k_d    = KW'(ONE_Q) - KW'(cfg_i.base_cutoff);
    end
    unique case (op_q)
      OP_BR_SC: r_d = r_new;
      OP_R0_RF: begin
        if (cfg_i.resonance_varies) begin
          r_d = r_new;
        end
      end
      OP_CF_BC: begin
        if (cfg_i.cutoff_varies) begin
          c_d = c_new;
          k_d = KW'(ONE_Q) - KW'(c_new);
        end
      end
      OP_FB_S, OP_PREV_NP, OP_S1_K, OP_S2_K, OP_S3_K, OP_S4_K: acc_d = p_q;
      OP_T_NS: fb_d = SW'(clamp(p_sum, SW_MIN, SW_MAX));
      OP_FB_P: x_d  = SW'(clamp(AW'(x_in_q) - p_sum, SW_MIN, SW_MAX));
      OP_X_C:  s1_d = S1_W'(clamp(p_sum, ONE_NEG, ONE_POS));
      OP_S1_C: s2_d = SW'(clamp(p_sum, SW_MIN, SW_MAX));
      OP_S2_C: s3_d = SW'(clamp(p_sum, SW_MIN, SW_MAX));
      OP_S3_C: s4_d = SW'(clamp(p_sum, SW_MIN, SW_MAX));
      default: ;
    endcase
  end

  // mode select and output register
  always_comb begin
    unique case (cfg_i.mode)
      MODE_LOWPASS:    y_sum = AW'(s4_q);
      MODE_HIGHPASS:   y_sum = AW'(x_in_q) - AW'(s4_q);
      MODE_BANDPASS:   y_sum = AW'(s4_q) - AW'(s1_q);
      MODE_BANDREJECT: y_sum = AW'(x_in_q) - AW'(s1_q);
      default:         y_sum = AW'(s4_q);
    endcase
    y_sat       = SW'(clamp(y_sum, SW_MIN, SW_MAX));
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_data_d  = FIELD_W'(y_sat);
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_q        <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      s4_q        <= '0;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      fb_q        <= fb_d;
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      s3_q        <= s3_d;
      s4_q        <= s4_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_in_q     <= x_in_d;
    cf_q       <= cf_d;
    rf_q       <= rf_d;
    c_q        <= c_d;
    k_q        <= k_d;
    r_q        <= r_d;
    x_q        <= x_d;
    acc_q      <= acc_d;
    p_q        <= p_d;
    out_data_q <= out_data_d;
  end

endmodule

[rtl/core/four_pole_multimode_filter.sv]
// Four-pole resonant multimode ladder filter: configuration registers and integration.
//
// Input stream (s_axis): one transfer carries sample_in, cutoff_factor and
// resonance_factor, all signed Q3.20. Output stream (m_axis): one transfer
// per input sample, carrying sample_out in signed Q3.20, saturated.
// Configuration: cfg_we_i writes register cfg_addr_i with cfg_wdata_i; write
// only while no sample is in flight.
// Operation: one shared multiplier performs every product; a sample needs three
// setup products and 13 per oversampling pass. s_axis_tready returns in the
// same cycle as m_axis_tvalid rises, so no new sample is taken until the
// result of the last one has been loaded into the output register.
// A finished result sits in the output register; if the receiver stalls the
// next sample is still taken and runs, and its result waits until the
// register is free.
// Reset clears the filter state and feedback, empties the output register
// and returns all configuration registers to their defaults.
module four_pole_multimode_filter import fpmf_pkg::*; #(
  parameter int OVERSAMPLE_PASSES = OVERSAMPLE_PASSES_DEF,
  parameter int SAMPLE_BITS       = SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sample_in [23:0], cutoff_factor [47:24], resonance_factor [71:48]
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // sample_out [23:0]
  output logic [FIELD_W-1:0]    m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic [WEIGHT_W-1:0] HALF_RST  = WEIGHT_W'(ONE_Q / 2);
  localparam logic [SCALE_W-1:0]  SCALE_RST = SCALE_W'(4 * ONE_Q);

  cfg_t       cfg_q, cfg_d;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FILTER_MODE:        cfg_d.mode = mode_e'(cfg_wdata_i[MODE_W-1:0]);
        REG_BASE_CUTOFF:        cfg_d.base_cutoff = cfg_wdata_i[WEIGHT_W-1:0];
        REG_BASE_RESONANCE:     cfg_d.base_resonance = cfg_wdata_i[WEIGHT_W-1:0];
        REG_RESONANCE_SCALE:    cfg_d.resonance_scale = cfg_wdata_i[SCALE_W-1:0];
        REG_FEEDBACK_SMOOTHING: cfg_d.feedback_smoothing = cfg_wdata_i[WEIGHT_W-1:0];
        REG_FEEDBACK_PHASE_MIX: cfg_d.feedback_phase_mix = cfg_wdata_i[WEIGHT_W-1:0];
        REG_CUTOFF_VARIES:      cfg_d.cutoff_varies = cfg_wdata_i[0];
        REG_RESONANCE_VARIES:   cfg_d.resonance_varies = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode               <= MODE_LOWPASS;
      cfg_q.base_cutoff        <= HALF_RST;
      cfg_q.base_resonance     <= '0;
      cfg_q.resonance_scale    <= SCALE_RST;
      cfg_q.feedback_smoothing <= HALF_RST;
      cfg_q.feedback_phase_mix <= HALF_RST;
      cfg_q.cutoff_varies      <= 1'b0;
      cfg_q.resonance_varies   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fpmf_ctrl #(
    .OVERSAMPLE_PASSES(OVERSAMPLE_PASSES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  fpmf_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .status_o          (status),
    .sample_in_i       (s_axis_tdata[FIELD_W-1:0]),
    .cutoff_factor_i   (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .resonance_factor_i(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .sample_out_o      (m_axis_tdata)
  );

endmodule

[rtl/core/fpmf_checker.sv]
// Port-level checks for the four-pole multimode filter, bound to the top level.
module fpmf_checker import fpmf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [FIELD_W-1:0] m_axis_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one sample at a time: input side busy straight after a transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while a sample is in flight");

  // a new result appears only as the block goes idle
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result presented while still busy");

endmodule

bind four_pole_multimode_filter fpmf_checker u_fpmf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
